FILE: rtl/first_fit_arena_allocator_unit_macros.svh
// Assertion macros for the first-fit arena allocator.
`ifndef FIRST_FIT_ARENA_ALLOCATOR_UNIT_MACROS_SVH
`define FIRST_FIT_ARENA_ALLOCATOR_UNIT_MACROS_SVH
`ifndef SYNTHESIS
`define FFA_ASSERT_IMP(label, clk, rst, a, c) \
  label: assert property (@(posedge clk) disable iff (rst) (a) |-> (c)) \
    else $error("implication check failed");
`define FFA_ASSERT_NXT(label, clk, rst, a, c) \
  label: assert property (@(posedge clk) disable iff (rst) (a) |=> (c)) \
    else $error("assertion failed");
`else
`define FFA_ASSERT_IMP(label, clk, rst, a, c)
`define FFA_ASSERT_NXT(label, clk, rst, a, c)
`endif
`endif

FILE: rtl/ffa_pkg.sv
// Package with shared constants and codes of the first-fit arena allocator.
`default_nettype none
package ffa_pkg;
  localparam int FREE_SLOTS_DEF = 16;
  localparam int USED_SLOTS_DEF = 16;
  localparam logic [31:0] ARENA_SIZE_RESET = 32'd65536;
  localparam logic [1:0] ST_OK = 2'd0;
  localparam logic [1:0] ST_OOM = 2'd1;
  localparam logic [1:0] ST_FULL = 2'd2;
  localparam logic [1:0] ST_UNKNOWN = 2'd3;
  localparam logic OP_ALLOC = 1'b0;
  localparam logic OP_FREE = 1'b1;
  localparam logic CFG_BASE = 1'b0;
  localparam logic CFG_SIZE = 1'b1;
endpackage
`default_nettype wire

FILE: rtl/first_fit_arena_allocator_unit.sv
// Top level of the first-fit arena allocator with its sequencer and tables.
// The input channel (valid, stall) carries one request word: opcode, request_bytes,
// align_log2 and free_address. The output channel (out_valid, out_stall) carries one
// result word per request: granted_address and status.
// The block takes a request only when idle and its output register is empty or being
// drained. An allocate scans the free table one entry a cycle. A free scans the used
// table, shifts it, then runs an insertion sort one compare a cycle and a merge pass
// one pair a cycle, shifting the table after each merge.
// Reset clears the counts, the bump offset, the arena base and the output valid flag
// and loads the default arena size. Table contents need no reset since entries are
// read below their counts only. While out_valid and out_stall are both high a finished
// result holds and no new request is taken; the configuration port is a write enable,
// index and data, used while idle; the block itself does not enforce this.
`default_nettype none
module first_fit_arena_allocator_unit
  import ffa_pkg::*;
#(
  parameter int FREE_SLOTS = FREE_SLOTS_DEF,
  parameter int USED_SLOTS = USED_SLOTS_DEF
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        valid,
  output logic             stall,
  input  wire logic        opcode,
  input  wire logic [31:0] request_bytes,
  input  wire logic [4:0]  align_log2,
  input  wire logic [31:0] free_address,
  output logic             out_valid,
  input  wire logic        out_stall,
  output logic [31:0]      granted_address,
  output logic [1:0]       status,
  input  wire logic        cfg_we,
  input  wire logic        cfg_index,
  input  wire logic [31:0] cfg_data
);
  `include "first_fit_arena_allocator_unit_macros.svh"

  localparam int FW = $clog2(FREE_SLOTS);
  localparam int UW = (USED_SLOTS > 1) ? $clog2(USED_SLOTS) : 1;
  localparam int FCW = $clog2(FREE_SLOTS + 1);
  localparam int UCW = $clog2(USED_SLOTS + 1);

  typedef enum logic [3:0] {
    S_IDLE, S_ASCAN, S_AREM, S_AAPP1, S_AAPP2, S_BUMP, S_USCAN, S_USHIFT,
    S_SORT, S_MERGE, S_MSHIFT, S_DONE
  } state_t;

  state_t state;
  logic [31:0] arena_base, arena_size, bump_offset;
  logic [31:0] free_start [FREE_SLOTS];
  logic [31:0] free_length [FREE_SLOTS];
  logic [31:0] used_start [USED_SLOTS];
  logic [FCW-1:0] free_count;
  logic [UCW-1:0] used_count;
  logic        op_r;
  logic [31:0] bytes_r, addr_r;
  logic [4:0]  alog_r;
  logic [FCW-1:0] i, j, k;
  logic [31:0] gap_s, gap_l, rem_s, rem_l, al_r;
  logic        has_gap, has_rem;
  logic [UCW-1:0] ui;

  logic [FW-1:0] ix, jx, jm1;
  logic [UW-1:0] uix;
  assign ix = i[FW-1:0];
  assign jx = j[FW-1:0];
  assign jm1 = FW'(j - FCW'(1));
  assign uix = ui[UW-1:0];

  // Shared address unit: aligns the current free entry and checks the fit.
  logic [32:0] amask, al33, adj33, need33, bl33, rem33;
  logic        fits;
  always_comb begin
    amask = (33'd1 << alog_r) - 33'd1;
    al33 = ({1'b0, free_start[ix]} + amask) & ~amask;
    adj33 = al33 - {1'b0, free_start[ix]};
    need33 = {1'b0, bytes_r} + adj33;
    bl33 = {1'b0, free_length[ix]};
    rem33 = bl33 - need33;
    fits = !al33[32] && (bl33 >= need33);
  end

  logic [32:0] aoff33, bsum33;
  always_comb begin
    aoff33 = ({1'b0, bump_offset} + amask) & ~amask;
    bsum33 = aoff33 + {1'b0, bytes_r};
  end

  logic [32:0] mend33, msum33;
  always_comb begin
    mend33 = {1'b0, free_start[ix]} + {1'b0, free_length[ix]};
    msum33 = {1'b0, free_length[ix]} + {1'b0, free_length[FW'(i + FCW'(1))]};
  end

  logic [31:0] ins_s, ins_l;

  assign stall = (state != S_IDLE) || (out_valid && out_stall);

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      out_valid <= 1'b0;
      free_count <= '0;
      used_count <= '0;
      bump_offset <= '0;
      arena_base <= '0;
      arena_size <= ARENA_SIZE_RESET;
    end else begin
      if (cfg_we) begin
        unique case (cfg_index)
          CFG_BASE: arena_base <= cfg_data;
          CFG_SIZE: arena_size <= cfg_data;
          default: ;
        endcase
      end
      unique case (state)
        S_IDLE: begin
          if (out_valid && !out_stall) out_valid <= 1'b0;
          if (valid && !stall) begin
            op_r <= opcode;
            bytes_r <= request_bytes;
            alog_r <= align_log2;
            addr_r <= free_address;
            granted_address <= '0;
            i <= '0;
            ui <= '0;
            if (opcode == OP_ALLOC && used_count >= UCW'(USED_SLOTS)) begin
              status <= ST_FULL;
              state <= S_DONE;
            end else begin
              status <= ST_OK;
              state <= (opcode == OP_ALLOC) ? S_ASCAN : S_USCAN;
            end
          end
        end
        S_ASCAN: begin
          if (i >= free_count) state <= S_BUMP;
          else if (fits) begin
            if (adj33 != 0 && rem33 != 0 && free_count >= FCW'(FREE_SLOTS)) begin
              status <= ST_FULL;
              state <= S_DONE;
            end else begin
              has_gap <= adj33 != 0;
              has_rem <= rem33 != 0;
              gap_s <= free_start[ix];
              gap_l <= adj33[31:0];
              rem_s <= al33[31:0] + bytes_r;
              rem_l <= rem33[31:0];
              al_r <= al33[31:0];
              k <= i;
              state <= S_AREM;
            end
          end else i <= i + FCW'(1);
        end
        S_AREM: begin
          if (k + FCW'(1) < free_count) begin
            free_start[k[FW-1:0]] <= free_start[FW'(k + FCW'(1))];
            free_length[k[FW-1:0]] <= free_length[FW'(k + FCW'(1))];
            k <= k + FCW'(1);
          end else begin
            free_count <= free_count - FCW'(1);
            used_start[used_count[UW-1:0]] <= al_r;
            used_count <= used_count + UCW'(1);
            granted_address <= al_r;
            state <= S_AAPP1;
          end
        end
        S_AAPP1: begin
          if (has_gap && free_count < FCW'(FREE_SLOTS)) begin
            free_start[free_count[FW-1:0]] <= gap_s;
            free_length[free_count[FW-1:0]] <= gap_l;
            free_count <= free_count + FCW'(1);
          end
          state <= S_AAPP2;
        end
        S_AAPP2: begin
          if (has_rem && free_count < FCW'(FREE_SLOTS)) begin
            free_start[free_count[FW-1:0]] <= rem_s;
            free_length[free_count[FW-1:0]] <= rem_l;
            free_count <= free_count + FCW'(1);
          end
          state <= S_DONE;
        end
        S_BUMP: begin
          if (bsum33 > {1'b0, arena_size}) status <= ST_OOM;
          else begin
            bump_offset <= bsum33[31:0];
            granted_address <= arena_base + aoff33[31:0];
            used_start[used_count[UW-1:0]] <= arena_base + aoff33[31:0];
            used_count <= used_count + UCW'(1);
          end
          state <= S_DONE;
        end
        S_USCAN: begin
          if (ui >= used_count) begin
            status <= ST_UNKNOWN;
            state <= S_DONE;
          end else if (used_start[uix] == addr_r) begin
            if (free_count >= FCW'(FREE_SLOTS)) begin
              status <= ST_FULL;
              state <= S_DONE;
            end else state <= S_USHIFT;
          end else ui <= ui + UCW'(1);
        end
        S_USHIFT: begin
          if (ui + UCW'(1) < used_count) begin
            used_start[uix] <= used_start[UW'(ui + UCW'(1))];
            ui <= ui + UCW'(1);
          end else begin
            used_count <= used_count - UCW'(1);
            free_start[free_count[FW-1:0]] <= addr_r;
            free_length[free_count[FW-1:0]] <= bytes_r;
            free_count <= free_count + FCW'(1);
            i <= FCW'(1);
            j <= FCW'(1);
            ins_s <= free_start[0];
            ins_l <= free_length[0];
            state <= S_SORT;
          end
        end
        S_SORT: begin
          if (i >= free_count) begin
            i <= '0;
            state <= S_MERGE;
          end else begin
            if (j == i) begin
              ins_s <= free_start[ix];
              ins_l <= free_length[ix];
            end
            if (j != '0 && free_start[jm1] > ((j == i) ? free_start[ix] : ins_s)) begin
              free_start[jx] <= free_start[jm1];
              free_length[jx] <= free_length[jm1];
              j <= j - FCW'(1);
            end else begin
              free_start[jx] <= (j == i) ? free_start[ix] : ins_s;
              free_length[jx] <= (j == i) ? free_length[ix] : ins_l;
              i <= i + FCW'(1);
              j <= i + FCW'(1);
            end
          end
        end
        S_MERGE: begin
          if (i + FCW'(1) >= free_count) state <= S_DONE;
          else if (mend33 == {1'b0, free_start[FW'(i + FCW'(1))]} && !msum33[32]) begin
            free_length[ix] <= msum33[31:0];
            k <= i + FCW'(1);
            state <= S_MSHIFT;
          end else i <= i + FCW'(1);
        end
        S_MSHIFT: begin
          if (k + FCW'(1) < free_count) begin
            free_start[k[FW-1:0]] <= free_start[FW'(k + FCW'(1))];
            free_length[k[FW-1:0]] <= free_length[FW'(k + FCW'(1))];
            k <= k + FCW'(1);
          end else begin
            free_count <= free_count - FCW'(1);
            state <= S_MERGE;
          end
        end
        S_DONE: begin
          if (!out_valid || !out_stall) begin
            out_valid <= 1'b1;
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  `FFA_ASSERT_IMP(a_counts, clk, rst, 1'b1,
    free_count <= FCW'(FREE_SLOTS) && used_count <= UCW'(USED_SLOTS))
  `FFA_ASSERT_IMP(a_grant_ok, clk, rst, out_valid && status != ST_OK, granted_address == 0)
  `FFA_ASSERT_NXT(a_hold, clk, rst, out_valid && out_stall,
    out_valid && $stable(granted_address) && $stable(status))
endmodule
`default_nettype wire
